// ----- src/tbc_pkg.sv -----
// Package for the tilt balance controller: shared widths, constants,
// the CORDIC arctangent table and the sequencer state type. No dependencies.
package tbc_pkg;

  // Default values of the top-level parameters, and the arctangent table length.
  localparam int unsigned CordicStepsDef = 14;
  localparam int unsigned AngleFracDef   = 13;
  localparam int unsigned AtanTabLen     = 20;

  // Shared divide-by-25 unit: dividend width and reciprocal ceil(2^32 / 25).
  localparam int unsigned DvdW     = 28;
  localparam int unsigned DivShift = 32;
  localparam logic [DvdW-1:0] DivRecip = 28'd171798692;

  localparam logic [15:0] LfsrDefault = 16'hACE1;
  localparam logic signed [35:0] PiQ30 = 36'sd3373259426;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_PROP_GAIN   = 3'd0,
    CFG_INTEG_GAIN  = 3'd1,
    CFG_INTEG_MIN   = 3'd2,
    CFG_INTEG_MAX   = 3'd3,
    CFG_BLEND_ALPHA = 3'd4,
    CFG_LEFT_TRIM   = 3'd5,
    CFG_RIGHT_TRIM  = 3'd6,
    CFG_PRBS_SEEDS  = 3'd7
  } cfg_idx_e;

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_BL_M1,
    ST_BL_M2,
    ST_BL_M3,
    ST_BL_M4,
    ST_BL_DIV,
    ST_BL_WAIT,
    ST_PI_P,
    ST_PI_I,
    ST_I_DIV,
    ST_I_WAIT,
    ST_OUT
  } seq_state_e;

  // Arctangent of 2^-i in Q.30 radians.
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // One step of the 16-bit LFSR with taps 16, 14, 13, 11.
  function automatic logic [15:0] lfsr_next(input logic [15:0] r);
    return {r[14:0], r[15] ^ r[13] ^ r[12] ^ r[10]};
  endfunction

endpackage

// ----- src/tbc_cordic.sv -----
// Iterative vectoring CORDIC: atan2(y, x) rounded to the tilt angle format.
// Depends on tbc_pkg for the arctangent table and pi.
module tbc_cordic #(
  parameter int unsigned Steps = 14,
  parameter int unsigned Frac  = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [16:0] y_i,
  input  logic signed [15:0] x_i,
  output logic               done_o,
  output logic signed [15:0] angle_o
);
  import tbc_pkg::*;

  localparam int unsigned CntW  = $clog2(Steps + 1);
  localparam int unsigned Shift = 30 - Frac;

  logic              busy_q, done_q, zero_q;
  logic [CntW-1:0]   cnt_q;
  logic signed [32:0] x_q, y_q;
  logic signed [35:0] z_q;
  logic signed [17:0] x_ext, y_ext;
  logic signed [32:0] dx, dy;
  logic signed [35:0] atan_v;
  logic [35:0]        z_mag;
  logic [35:0]        r_mag;

  assign x_ext  = 18'(x_i);
  assign y_ext  = 18'(y_i);
  assign dx     = y_q >>> cnt_q;
  assign dy     = x_q >>> cnt_q;
  assign atan_v = $signed({4'd0, atan_q30(5'(cnt_q))});

  // Operand setup on start, then one micro-rotation per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (x_i == 16'sd0) && (y_i == 17'sd0);
      if (x_i < 0) begin
        z_q <= (y_i >= 0) ? PiQ30 : -PiQ30;
        x_q <= 33'(-x_ext) <<< 14;
        y_q <= 33'(-y_ext) <<< 14;
      end else begin
        z_q <= '0;
        x_q <= 33'(x_ext) <<< 14;
        y_q <= 33'(y_ext) <<< 14;
      end
    end else if (busy_q) begin
      if (y_q >= 0) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_v;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_v;
      end
    end
  end

  // Round half away from zero to the angle format and saturate.
  assign z_mag = z_q[35] ? 36'(-z_q) : 36'(z_q);
  assign r_mag = (z_mag + (36'd1 << (Shift - 1))) >> Shift;

  always_comb begin
    if (zero_q) begin
      angle_o = '0;
    end else if (z_q[35]) begin
      angle_o = (r_mag > 36'd32768) ? -16'sd32768 : 16'(-$signed(r_mag));
    end else begin
      angle_o = (r_mag > 36'd32767) ? 16'sd32767 : 16'(r_mag);
    end
  end

  assign done_o = done_q;

endmodule

// ----- src/tbc_div.sv -----
// Shared divide-by-25 unit by reciprocal multiplication.
// Depends on tbc_pkg for the dividend width and the reciprocal.
module tbc_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [tbc_pkg::DvdW-1:0] dividend_i,
  output logic                     done_o,
  output logic [tbc_pkg::DvdW-1:0] quotient_o
);
  import tbc_pkg::*;

  logic              busy_q, done_q;
  logic [DvdW-1:0]   dvd_q, quo_q;
  logic [2*DvdW-1:0] prod;

  // The reciprocal is exact for every dividend below 2^30.
  assign prod = dvd_q * DivRecip;

  // Control: start loads the operand register, then busy_q loads the quotient and raises done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q;
    end
  end

  // Datapath: capture the dividend, then keep the scaled-down product.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
    end
    if (busy_q) begin
      quo_q <= DvdW'(prod >> DivShift);
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- src/tilt_balance_controller.sv -----
// Tilt balance controller: complementary-filter tilt estimate and PI control.
// Depends on tbc_pkg, tbc_cordic and tbc_div.
//
// Usage: one IMU sample enters per transfer on the s_axis channel; one result
// (both throttles and the tilt estimate) leaves per transfer on m_axis.
// Configuration registers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i; the user must write them only while the block is idle, which
// the block itself does not enforce. A write of the seed register reloads
// both PRBS generators.
// Each sample runs through a sequencer around one shared multiplier, an
// iterative CORDIC (CORDIC_STEPS rotations) and a divide-by-25 unit that
// serves both rounding divisions. The first sample after reset skips the
// blend. s_axis_tready is high only between samples, while the sequencer is
// idle, so a new sample is accepted only once the last one has left it.
// The result sits in an output register; the next sample is accepted while
// it waits, but the block holds its new result until the old one is taken.
// Reset restores the register defaults, clears the tilt, the first-sample
// flag and the integral term, and loads both LFSRs with 0xACE1.
module tilt_balance_controller #(
  parameter int unsigned CORDIC_STEPS    = tbc_pkg::CordicStepsDef,
  parameter int unsigned ANGLE_FRAC_BITS = tbc_pkg::AngleFracDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input samples.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // accel_x[15:0], accel_z[31:16], gyro_y[47:32], target_angle[63:48],
  // inject_noise[64], advance_prbs[65], zero fill[71:66]
  input  logic [71:0] s_axis_tdata,
  // Results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // left_throttle[14:0], right_throttle[29:15], tilt_estimate[45:30],
  // zero fill[47:46]
  output logic [47:0] m_axis_tdata,
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import tbc_pkg::*;

  localparam int unsigned F = ANGLE_FRAC_BITS;
  // Blend divisor 65536 * 102400 is 25 * 2^28.
  localparam int unsigned BlShift = 28;
  localparam logic [53:0] BlHalf   = 54'd3355443200;
  localparam logic [59:0] PRound   = 60'd1 << (F - 1);
  localparam logic [59:0] IRound   = 60'd50 << F;

  // Configuration registers.
  logic [15:0]        kp_q, ki_q, alpha_q;
  logic signed [15:0] imin_q, imax_q;
  logic [14:0]        ltrim_q, rtrim_q;

  // Filter and controller state.
  seq_state_e         state_q, state_d;
  logic signed [15:0] tilt_q, tilt_d;
  logic               first_q, first_d;
  logic signed [23:0] it_q, it_d;
  logic [15:0]        lfsr_l_q, lfsr_r_q;

  // Per-sample working registers.
  logic signed [15:0] gy_q, tgt_q, ang_q, ang_d;
  logic               noise_q, adv_q;
  logic signed [53:0] acc_q, acc_d;
  logic signed [33:0] up_q, up_d;
  logic [DvdW-1:0]    idvd_q, idvd_d;
  logic               ineg_q, ineg_d;

  // Output register.
  logic               m_valid_q;
  logic [14:0]        lthr_q, rthr_q;
  logic signed [15:0] tilt_out_q;

  // Shared multiplier and helpers.
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] prod;
  logic [51:0]        p_mag;
  logic [59:0]        up_mag;
  logic signed [16:0] err;
  logic [53:0]        acc_mag;
  logic               in_xfer, load_out;

  // Unit handshakes.
  logic               cor_start, cor_done;
  logic signed [15:0] cor_angle;
  logic               div_start, div_done;
  logic [DvdW-1:0]    div_dvd, div_q;

  // Final arithmetic.
  logic signed [DvdW:0] q_s;
  logic signed [35:0] it_sum, it_lo, it_hi;
  logic signed [39:0] u_sum;
  logic signed [41:0] vl, vr, nl, nr;
  logic [14:0]        lthr, rthr;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cor_start     = in_xfer;
  assign err           = 17'(tgt_q) - 17'(tilt_q);
  assign acc_mag       = acc_q[53] ? 54'(-acc_q) : 54'(acc_q);
  assign prod          = mul_a * mul_b;
  assign p_mag         = prod[51] ? 52'(-prod) : 52'(prod);
  assign up_mag        = ((60'(p_mag) << 8) + PRound) >> F;

  // Throttle rounding to Q7.8 (halves away from zero) and clamping.
  function automatic logic [14:0] throttle(input logic signed [41:0] v);
    logic [41:0] mag;
    logic [41:0] r;
    mag = v[41] ? 42'(-v) : 42'(v);
    r   = (mag + 42'd256) >> 9;
    if (v[41]) return 15'd0;
    else if (r > 42'd25600) return 15'd25600;
    else return 15'(r);
  endfunction

  tbc_cordic #(
    .Steps (CORDIC_STEPS),
    .Frac  (ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .y_i     (-17'(signed'(s_axis_tdata[15:0]))),
    .x_i     (s_axis_tdata[31:16]),
    .done_o  (cor_done),
    .angle_o (cor_angle)
  );

  // Both divisions round by adding half the divisor, drop the power of two
  // and leave the division by 25 to the shared unit.
  assign div_start = (state_q == ST_BL_DIV) || (state_q == ST_I_DIV);
  assign div_dvd   = (state_q == ST_BL_DIV) ? DvdW'((acc_mag + BlHalf) >> BlShift) : idvd_q;

  tbc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // Signed quotient, integral update and throttle sums.
  assign q_s    = ineg_q ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign it_sum = 36'(it_q) + 36'(q_s);
  assign it_lo  = 36'(imin_q) <<< 8;
  assign it_hi  = 36'(imax_q) <<< 8;
  assign u_sum  = 40'(up_q) + 40'(it_q);
  assign nl     = !noise_q ? 42'sd0 : (lfsr_l_q[0] ? 42'sd131072 : -42'sd131072);
  assign nr     = !noise_q ? 42'sd0 : (lfsr_r_q[0] ? 42'sd131072 : -42'sd131072);
  assign vl     = ($signed({27'd0, ltrim_q}) <<< 9) + 42'(u_sum) + nl;
  assign vr     = ($signed({27'd0, rtrim_q}) <<< 9) - 42'(u_sum) + nr;
  assign lthr   = throttle(vl);
  assign rthr   = throttle(vr);
  assign load_out = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  // Sequencer: next state, multiplier operands and working-register updates.
  always_comb begin
    state_d = state_q;
    tilt_d  = tilt_q;
    first_d = first_q;
    it_d    = it_q;
    ang_d   = ang_q;
    acc_d   = acc_q;
    up_d    = up_q;
    idvd_d  = idvd_q;
    ineg_d  = ineg_q;
    mul_a   = $signed({18'd0, alpha_q});
    mul_b   = 18'(tilt_q);
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_CORDIC;
      end
      ST_CORDIC: begin
        if (cor_done) begin
          ang_d = cor_angle;
          if (!first_q) begin
            tilt_d  = cor_angle;
            first_d = 1'b1;
            state_d = ST_PI_P;
          end else begin
            state_d = ST_BL_M1;
          end
        end
      end
      ST_BL_M1: begin
        acc_d   = 54'(prod);
        state_d = ST_BL_M2;
      end
      ST_BL_M2: begin
        mul_a   = 34'(ang_q);
        mul_b   = 18'sd65536 - $signed({2'd0, alpha_q});
        acc_d   = acc_q + 54'(prod);
        state_d = ST_BL_M3;
      end
      ST_BL_M3: begin
        mul_a   = acc_q[33:0];
        mul_b   = 18'sd102400;
        acc_d   = 54'(prod);
        state_d = ST_BL_M4;
      end
      ST_BL_M4: begin
        mul_b   = 18'(gy_q);
        acc_d   = acc_q + (54'(prod) <<< F);
        state_d = ST_BL_DIV;
      end
      ST_BL_DIV: begin
        state_d = ST_BL_WAIT;
      end
      ST_BL_WAIT: begin
        if (div_done) begin
          if (acc_q[53]) begin
            tilt_d = (div_q > DvdW'(32768)) ? -16'sd32768 : 16'(-$signed({1'b0, div_q}));
          end else begin
            tilt_d = (div_q > DvdW'(32767)) ? 16'sd32767 : 16'(div_q);
          end
          state_d = ST_PI_P;
        end
      end
      ST_PI_P: begin
        mul_a   = $signed({18'd0, kp_q});
        mul_b   = 18'(err);
        up_d    = prod[51] ? -$signed(34'(up_mag)) : $signed(34'(up_mag));
        state_d = ST_PI_I;
      end
      ST_PI_I: begin
        mul_a   = $signed({18'd0, ki_q});
        mul_b   = 18'(err);
        idvd_d  = DvdW'(((60'(p_mag) << 8) + IRound) >> (F + 2));
        ineg_d  = prod[51];
        state_d = ST_I_DIV;
      end
      ST_I_DIV: begin
        state_d = ST_I_WAIT;
      end
      ST_I_WAIT: begin
        if (div_done) begin
          if (it_sum > it_hi) begin
            it_d = 24'(it_hi);
          end else begin
            it_d = 24'(it_sum);
          end
          if (it_sum < it_lo || (it_hi < it_lo)) begin
            if (it_sum < it_lo || it_hi < it_lo) it_d = 24'(it_lo);
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tilt_q    <= '0;
      first_q   <= 1'b0;
      it_q      <= '0;
      m_valid_q <= 1'b0;
      kp_q      <= 16'd256;
      ki_q      <= 16'd0;
      imin_q    <= -16'sd2560;
      imax_q    <= 16'sd2560;
      alpha_q   <= 16'd64881;
      ltrim_q   <= 15'd12800;
      rtrim_q   <= 15'd12800;
      lfsr_l_q  <= LfsrDefault;
      lfsr_r_q  <= LfsrDefault;
    end else begin
      state_q <= state_d;
      tilt_q  <= tilt_d;
      first_q <= first_d;
      it_q    <= it_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (load_out && adv_q) begin
        lfsr_l_q <= lfsr_next(lfsr_l_q);
        lfsr_r_q <= lfsr_next(lfsr_r_q);
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_PROP_GAIN:   kp_q    <= cfg_data_i[15:0];
          CFG_INTEG_GAIN:  ki_q    <= cfg_data_i[15:0];
          CFG_INTEG_MIN:   imin_q  <= cfg_data_i[15:0];
          CFG_INTEG_MAX:   imax_q  <= cfg_data_i[15:0];
          CFG_BLEND_ALPHA: alpha_q <= cfg_data_i[15:0];
          CFG_LEFT_TRIM:   ltrim_q <= cfg_data_i[14:0];
          CFG_RIGHT_TRIM:  rtrim_q <= cfg_data_i[14:0];
          CFG_PRBS_SEEDS: begin
            lfsr_l_q <= (cfg_data_i[15:0] == 16'd0) ? LfsrDefault : cfg_data_i[15:0];
            lfsr_r_q <= (cfg_data_i[31:16] == 16'd0) ? LfsrDefault : cfg_data_i[31:16];
          end
          default: ;
        endcase
      end
    end
  end

  // Payload registers: sample fields, working values and the result.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      gy_q    <= s_axis_tdata[47:32];
      tgt_q   <= s_axis_tdata[63:48];
      noise_q <= s_axis_tdata[64];
      adv_q   <= s_axis_tdata[65];
    end
    ang_q  <= ang_d;
    acc_q  <= acc_d;
    up_q   <= up_d;
    idvd_q <= idvd_d;
    ineg_q <= ineg_d;
    if (load_out) begin
      lthr_q     <= lthr;
      rthr_q     <= rthr;
      tilt_out_q <= tilt_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, tilt_out_q, rthr_q, lthr_q};

endmodule
